[rtl/ndim_histogram_binner_defines.svh]
// Assertion macros used by the histogram binner controller.
// Depends on nothing; included by files that assert.
`ifndef NDIM_HISTOGRAM_BINNER_DEFINES_SVH
`define NDIM_HISTOGRAM_BINNER_DEFINES_SVH

`define NHB_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`define NHB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/nhb_pkg.sv]
// Types and constants of the histogram binner.
// Depends on nothing.
package nhb_pkg;

    localparam int unsigned CELL_AW = 12;
    localparam int unsigned CELLS = 4096;
    localparam int unsigned DIV_STEPS = 32;

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic [2:0] REG_MIN_X = 3'd0;
    localparam logic [2:0] REG_MIN_Y = 3'd1;
    localparam logic [2:0] REG_MIN_Z = 3'd2;
    localparam logic [2:0] REG_WIDTH_X = 3'd3;
    localparam logic [2:0] REG_WIDTH_Y = 3'd4;
    localparam logic [2:0] REG_WIDTH_Z = 3'd5;

    typedef struct packed {
        logic [1:0] cmd;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic [15:0] weight;
        logic [3:0] sel_x;
        logic [3:0] sel_y;
        logic [3:0] sel_z;
    } in_item_t;

    typedef struct packed {
        logic [3:0] out_bucket_x;
        logic [3:0] out_bucket_y;
        logic [3:0] out_bucket_z;
        logic [31:0] cell_count;
        logic [47:0] total_count;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_WAIT,
        ST_WRITE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic div_step;
        logic mem_read;
        logic mem_write;
        logic out_load;
        logic total_clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic is_add;
        logic is_clear;
        logic is_nop;
    } ctrl_stat_t;

endpackage

[rtl/nhb_ctrl.sv]
// Controller state machine of the histogram binner.
// Depends on nhb_pkg and ndim_histogram_binner_defines.svh.
`include "ndim_histogram_binner_defines.svh"
module nhb_ctrl (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  logic m_valid,
    input  logic m_ready,
    input  nhb_pkg::ctrl_stat_t stat,
    output nhb_pkg::ctrl_cmd_t cmd
);
    nhb_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nhb_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            nhb_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) begin
                    state_next = stat.is_clear ? nhb_pkg::ST_OUT : nhb_pkg::ST_IDLE;
                end
            end
            nhb_pkg::ST_IDLE: begin
                s_ready = !m_valid || m_ready;
                if (s_valid && s_ready) begin
                    cmd.load = 1'b1;
                    state_next = nhb_pkg::ST_DIV;
                end
            end
            nhb_pkg::ST_DIV: begin
                if (stat.is_clear) begin
                    cmd.total_clear = 1'b1;
                    state_next = nhb_pkg::ST_CLEAR;
                end else if (stat.is_nop) begin
                    state_next = nhb_pkg::ST_OUT;
                end else if (!stat.is_add) begin
                    state_next = nhb_pkg::ST_READ;
                end else if (stat.div_done) begin
                    state_next = nhb_pkg::ST_READ;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            nhb_pkg::ST_READ: begin
                cmd.mem_read = 1'b1;
                state_next = nhb_pkg::ST_WAIT;
            end
            nhb_pkg::ST_WAIT: begin
                state_next = stat.is_add ? nhb_pkg::ST_WRITE : nhb_pkg::ST_OUT;
            end
            nhb_pkg::ST_WRITE: begin
                cmd.mem_write = 1'b1;
                state_next = nhb_pkg::ST_OUT;
            end
            nhb_pkg::ST_OUT: begin
                if (!m_valid || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next = nhb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = nhb_pkg::ST_CLEAR;
            end
        endcase
    end

    `NHB_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_ready, state_reg == nhb_pkg::ST_IDLE, "ready outside idle")
    `NHB_ASSERT_IMPL(a_write_add, aclk, aresetn, cmd.mem_write, stat.is_add, "write without add")
    `NHB_ASSERT_NEXT(a_load_div, aclk, aresetn, cmd.load, state_reg == nhb_pkg::ST_DIV, "load not followed by binning")
endmodule

[rtl/nhb_datapath.sv]
// Datapath of the histogram binner: config registers, serial dividers,
// count memory, totals and output register. Depends on nhb_pkg.
module nhb_datapath #(
    parameter int unsigned BINS = 14,
    parameter int unsigned AXES = 3
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  nhb_pkg::in_item_t s_data,
    input  nhb_pkg::ctrl_cmd_t cmd,
    output nhb_pkg::ctrl_stat_t stat,
    output logic m_valid,
    input  logic m_ready,
    output nhb_pkg::out_item_t m_data
);
    localparam logic [47:0] TOTAL_MAX = {48{1'b1}};

    logic signed [31:0] min_reg [3];
    logic [30:0] width_reg [3];
    logic [31:0] mem [nhb_pkg::CELLS];
    logic [nhb_pkg::CELL_AW-1:0] clr_addr_reg;
    nhb_pkg::in_item_t item_reg;
    logic [32:0] diff_reg [3];
    logic [32:0] rem_reg [3];
    logic [32:0] quo_reg [3];
    logic [30:0] w_reg [3];
    logic [1:0] cls_reg [3];
    logic [5:0] step_reg;
    logic [31:0] rdata_reg;
    logic [31:0] cell_reg;
    logic [47:0] total_reg;
    logic out_valid_reg;
    nhb_pkg::out_item_t out_reg;
    logic [3:0] bkt [3];
    logic [nhb_pkg::CELL_AW-1:0] addr;
    logic [32:0] sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                min_reg[i] <= '0;
                width_reg[i] <= 31'd65536;
            end
        end else if (cfg_valid) begin
            case (cfg_index)
                nhb_pkg::REG_MIN_X: min_reg[0] <= cfg_data;
                nhb_pkg::REG_MIN_Y: min_reg[1] <= cfg_data;
                nhb_pkg::REG_MIN_Z: min_reg[2] <= cfg_data;
                nhb_pkg::REG_WIDTH_X: width_reg[0] <= cfg_data[30:0];
                nhb_pkg::REG_WIDTH_Y: width_reg[1] <= cfg_data[30:0];
                nhb_pkg::REG_WIDTH_Z: width_reg[2] <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Each axis classifies below, above or inside and runs a restoring divide; the quotient sets an inside bucket.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg <= '0;
            step_reg <= '0;
        end else if (cmd.load) begin
            item_reg <= s_data;
            step_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                logic signed [32:0] d;
                logic [30:0] w;
                logic [39:0] lim;
                case (i)
                    0: d = $signed({s_data.coord_x[31], s_data.coord_x})
                        - $signed({min_reg[0][31], min_reg[0]});
                    1: d = $signed({s_data.coord_y[31], s_data.coord_y})
                        - $signed({min_reg[1][31], min_reg[1]});
                    default: d = $signed({s_data.coord_z[31], s_data.coord_z})
                        - $signed({min_reg[2][31], min_reg[2]});
                endcase
                w = (width_reg[i] == '0) ? 31'd1 : width_reg[i];
                lim = 40'(w) * 40'(BINS);
                w_reg[i] <= w;
                diff_reg[i] <= d;
                rem_reg[i] <= '0;
                quo_reg[i] <= '0;
                if (d[32]) cls_reg[i] <= 2'd0;
                else if (40'(d) >= lim) cls_reg[i] <= 2'd2;
                else cls_reg[i] <= 2'd1;
            end
        end else if (cmd.div_step) begin
            step_reg <= step_reg + 6'd1;
            for (int i = 0; i < 3; i++) begin
                logic [33:0] r;
                r = {rem_reg[i], diff_reg[i][31 - step_reg[4:0]]};
                if (r >= 34'(w_reg[i])) begin
                    rem_reg[i] <= 33'(r - 34'(w_reg[i]));
                    quo_reg[i] <= {quo_reg[i][31:0], 1'b1};
                end else begin
                    rem_reg[i] <= r[32:0];
                    quo_reg[i] <= {quo_reg[i][31:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [32:0] b;
            case (cls_reg[i])
                2'd0: b = '0;
                2'd2: b = 33'(BINS) + 33'd1;
                default: b = quo_reg[i] + 33'd1;
            endcase
            if (i >= AXES) bkt[i] = '0;
            else if (b > 33'd15) bkt[i] = 4'd15;
            else bkt[i] = b[3:0];
        end
        if (item_reg.cmd == nhb_pkg::CMD_ADD) addr = {bkt[2], bkt[1], bkt[0]};
        else addr = {item_reg.sel_z, item_reg.sel_y, item_reg.sel_x};
        sum = 33'(rdata_reg) + 33'(item_reg.weight);
    end

    assign stat.clr_done = (clr_addr_reg == '1);
    assign stat.div_done = (step_reg == 6'(nhb_pkg::DIV_STEPS));
    assign stat.is_add = (item_reg.cmd == nhb_pkg::CMD_ADD);
    assign stat.is_clear = (item_reg.cmd == nhb_pkg::CMD_CLEAR);
    assign stat.is_nop = (item_reg.cmd == nhb_pkg::CMD_NOP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.clr_step) begin
            mem[clr_addr_reg] <= '0;
        end else if (cmd.mem_write) begin
            mem[addr] <= cell_reg;
        end
        if (cmd.mem_read) begin
            rdata_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else if (cmd.total_clear) begin
            total_reg <= '0;
        end else if (cmd.mem_write) begin
            if (total_reg > TOTAL_MAX - 48'(item_reg.weight)) total_reg <= TOTAL_MAX;
            else total_reg <= total_reg + 48'(item_reg.weight);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg <= '0;
        end else if (cmd.load) begin
            cell_reg <= '0;
        end else if (stat.is_add && !cmd.mem_read && !cmd.mem_write && !cmd.div_step) begin
            cell_reg <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else if (!stat.is_add && (item_reg.cmd == nhb_pkg::CMD_READ)
            && !cmd.mem_read && !cmd.div_step) begin
            cell_reg <= rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.out_bucket_x <= stat.is_add ? bkt[0] : 4'd0;
            out_reg.out_bucket_y <= stat.is_add ? bkt[1] : 4'd0;
            out_reg.out_bucket_z <= stat.is_add ? bkt[2] : 4'd0;
            out_reg.cell_count <= cell_reg;
            out_reg.total_count <= total_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;
endmodule

[rtl/ndim_histogram_binner.sv]
// An add runs the serial binning divide, one quotient bit per cycle on each
// axis, then a read and write of the count memory; a read only reads it.
// One request at a time: a new one is taken only after the last result is loaded.
// Reset is synchronous, active low; it then sweeps 4096 memory words, one a
// cycle, before the first request is taken. A clear request repeats that sweep.
module ndim_histogram_binner #(
    parameter int unsigned BINS = 14,
    parameter int unsigned AXES = 3
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [31:0] cfg_data,
    input  logic s_valid,
    output logic s_ready,
    input  nhb_pkg::in_item_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output nhb_pkg::out_item_t m_data
);
    nhb_pkg::ctrl_cmd_t cmd;
    nhb_pkg::ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    nhb_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    nhb_datapath #(.BINS(BINS), .AXES(AXES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .s_data(s_data), .cmd(cmd),
        .stat(stat), .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule
